### src/ala_pkg.sv
// Shared types, codes and cell update functions for the aging life grid.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ala_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_ALIVE = 2'd1;
    localparam logic [1:0] ST_DEAD  = 2'd2;

    localparam logic [1:0] CFG_MAX_AGE        = 2'd0;
    localparam logic [1:0] CFG_MAX_SPAWN_AGE  = 2'd1;
    localparam logic [1:0] CFG_MAX_SPIRIT_AGE = 2'd2;

    localparam logic [5:0] RST_MAX_AGE        = 6'd50;
    localparam logic [5:0] RST_MAX_SPAWN_AGE  = 6'd30;
    localparam logic [5:0] RST_MAX_SPIRIT_AGE = 6'd20;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] col;
        logic [5:0] row;
        logic [1:0] write_state;
        logic [5:0] write_age;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  cell_state;
        logic [5:0]  cell_age;
        logic        young_found;
        logic [31:0] generations_lived;
    } out_item_t;

    typedef struct packed {
        logic [5:0] max_age;
        logic [5:0] max_spawn_age;
        logic [5:0] max_spirit_age;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] col;
        logic [5:0] row;
        logic [1:0] wst;
        logic [5:0] wage;
        logic       in_grid;
    } qitem_t;

    function automatic logic is_young(input logic [7:0] c, input logic [5:0] spawn);
        is_young = (c[7:6] == ST_ALIVE) && (c[5:0] < spawn);
    endfunction

    function automatic logic [7:0] next_cell(input logic [7:0] c, input logic [3:0] n,
                                             input cfg_t cfg);
        logic [1:0] st;
        logic [5:0] age;
        st  = c[7:6];
        age = c[5:0];
        if (st != ST_ALIVE && n == 4'd3)
            next_cell = {ST_ALIVE, 6'd0};
        else if (st == ST_ALIVE && (n == 4'd2 || n == 4'd3) && age < cfg.max_age)
            next_cell = {ST_ALIVE, 6'(age + 6'd1)};
        else if (st == ST_ALIVE)
            next_cell = {ST_DEAD, 6'd0};
        else if (st == ST_DEAD && age < cfg.max_spirit_age)
            next_cell = {ST_DEAD, 6'(age + 6'd1)};
        else
            next_cell = {ST_EMPTY, age};
    endfunction

endpackage

### src/ala_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on ala_pkg.
`timescale 1ns / 1ps
module ala_front #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ala_pkg::in_item_t in_data,
    output logic            q_valid,
    output ala_pkg::qitem_t q_item,
    input  logic            q_pop
);
    import ala_pkg::*;

    qitem_t     ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    qitem_t     cls;

    always_comb
    begin
        cls.mode    = in_data.mode;
        cls.col     = in_data.col;
        cls.row     = in_data.row;
        cls.wst     = (in_data.write_state == 2'd3) ? ST_EMPTY : in_data.write_state;
        cls.wage    = in_data.write_age;
        cls.in_grid = (32'(in_data.col) < GRID_WIDTH) && (32'(in_data.row) < GRID_HEIGHT);
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, q_pop});
        end
    end

endmodule

### src/ala_back.sv
// Back end: grid memory in two banks, generation sweep with a row window, result register.
// Depends on ala_pkg.
`timescale 1ns / 1ps
module ala_back #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ala_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  ala_pkg::qitem_t  q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output ala_pkg::out_item_t out_data
);
    import ala_pkg::*;

    localparam int N   = GRID_WIDTH * GRID_HEIGHT;
    localparam int IW  = (N > 1) ? $clog2(N) : 1;
    localparam int AW  = IW + 1;
    localparam int PW  = $clog2(N + GRID_WIDTH + 2);
    localparam int XW  = $clog2(GRID_WIDTH);
    localparam int YW  = $clog2(GRID_HEIGHT);
    localparam int SRL = 2 * GRID_WIDTH + 3;
    localparam int CTR = GRID_WIDTH + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [7:0]  mem [2**AW];
    logic [7:0]  rdata_reg;
    logic [7:0]  sr_reg [SRL];

    logic [2:0]  state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [IW-1:0] cidx_reg, cidx_next;
    logic [XW-1:0] cx_reg, cx_next;
    logic [YW-1:0] cy_reg, cy_next;
    logic        sel_reg, sel_next;
    logic        yacc_reg, yacc_next;
    logic        young_reg, young_next;
    logic [31:0] gen_reg, gen_next;
    logic        clr_item_reg, clr_item_next;
    qitem_t      cur_reg, cur_next;
    logic [IW-1:0] cur_idx_reg, cur_idx_next;
    logic        v1_reg, v2_reg, pad1_reg;
    logic [PW-1:0] q1_reg, q2_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata;
    logic [IW-1:0] q_idx;
    logic        cvalid, clast, cyoung;
    logic [7:0]  nb [8];
    logic [7:0]  nmask;
    logic [3:0]  ncnt;
    logic        slot_live;

    assign q_idx     = IW'(32'(q_item.row) * GRID_WIDTH + 32'(q_item.col));
    assign slot_live = (state_reg == S_STEP) && (p_reg <= PW'(N + GRID_WIDTH));
    assign cvalid    = v2_reg && (q2_reg >= PW'(CTR));
    assign clast     = (cx_reg == XW'(GRID_WIDTH - 1)) && (cy_reg == YW'(GRID_HEIGHT - 1));
    assign cyoung    = is_young(sr_reg[CTR], cfg.max_spawn_age);

    always_comb
    begin
        nb[0] = sr_reg[0];
        nb[1] = sr_reg[1];
        nb[2] = sr_reg[2];
        nb[3] = sr_reg[GRID_WIDTH];
        nb[4] = sr_reg[GRID_WIDTH + 2];
        nb[5] = sr_reg[2 * GRID_WIDTH];
        nb[6] = sr_reg[2 * GRID_WIDTH + 1];
        nb[7] = sr_reg[2 * GRID_WIDTH + 2];
        nmask[0] = (cy_reg != YW'(GRID_HEIGHT - 1)) && (cx_reg != XW'(GRID_WIDTH - 1));
        nmask[1] = (cy_reg != YW'(GRID_HEIGHT - 1));
        nmask[2] = (cy_reg != YW'(GRID_HEIGHT - 1)) && (cx_reg != '0);
        nmask[3] = (cx_reg != XW'(GRID_WIDTH - 1));
        nmask[4] = (cx_reg != '0);
        nmask[5] = (cy_reg != '0) && (cx_reg != XW'(GRID_WIDTH - 1));
        nmask[6] = (cy_reg != '0);
        nmask[7] = (cy_reg != '0) && (cx_reg != '0);
        ncnt = '0;
        for (int i = 0; i < 8; i++)
            ncnt = 4'(ncnt + {3'b0, nmask[i] && is_young(nb[i], cfg.max_spawn_age)});
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        cidx_next      = cidx_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        sel_next       = sel_reg;
        yacc_next      = yacc_reg;
        young_next     = young_reg;
        gen_next       = gen_reg;
        clr_item_next  = clr_item_reg;
        cur_next       = cur_reg;
        cur_idx_next   = cur_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = '0;
        raddr          = '0;
        wdata          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    cur_next     = q_item;
                    cur_idx_next = q_idx;
                    case (q_item.mode)
                        MODE_WRITE:
                        begin
                            we         = q_item.in_grid;
                            waddr      = {sel_reg, q_idx};
                            wdata      = {q_item.wst, q_item.wage};
                            state_next = S_READ;
                        end
                        MODE_READ:
                            state_next = S_READ;
                        MODE_STEP:
                        begin
                            p_next     = '0;
                            cidx_next  = '0;
                            cx_next    = '0;
                            cy_next    = '0;
                            yacc_next  = 1'b0;
                            state_next = S_STEP;
                        end
                        default:
                        begin
                            cidx_next     = '0;
                            gen_next      = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLR;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                we        = 1'b1;
                waddr     = {sel_reg, cidx_reg};
                wdata     = '0;
                cidx_next = IW'(cidx_reg + 1'b1);
                if (cidx_reg == IW'(N - 1))
                    state_next = clr_item_reg ? S_READ : S_IDLE;
            end
            S_STEP:
            begin
                re    = (p_reg < PW'(N));
                raddr = {sel_reg, p_reg[IW-1:0]};
                if (slot_live)
                    p_next = PW'(p_reg + 1'b1);
                if (cvalid)
                begin
                    we        = 1'b1;
                    waddr     = {!sel_reg, cidx_reg};
                    wdata     = next_cell(sr_reg[CTR], ncnt, cfg);
                    cidx_next = IW'(cidx_reg + 1'b1);
                    yacc_next = yacc_reg || cyoung;
                    if (cx_reg == XW'(GRID_WIDTH - 1))
                    begin
                        cx_next = '0;
                        cy_next = YW'(cy_reg + 1'b1);
                    end
                    else
                        cx_next = XW'(cx_reg + 1'b1);
                    if (clast)
                    begin
                        sel_next   = !sel_reg;
                        young_next = yacc_reg || cyoung;
                        if ((yacc_reg || cyoung) && gen_reg != 32'hFFFF_FFFF)
                            gen_next = gen_reg + 32'd1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                re         = 1'b1;
                raddr      = {sel_reg, cur_idx_reg};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.cell_state        = cur_reg.in_grid ? rdata_reg[7:6] : ST_EMPTY;
                    out_data_next.cell_age          = cur_reg.in_grid ? rdata_reg[5:0] : 6'd0;
                    out_data_next.young_found       = young_reg;
                    out_data_next.generations_lived = gen_reg;
                    state_next                      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            sr_reg[0] <= pad1_reg ? 8'd0 : rdata_reg;
            for (int i = 1; i < SRL; i++)
                sr_reg[i] <= sr_reg[i-1];
        end
        q1_reg       <= p_reg;
        q2_reg       <= q1_reg;
        pad1_reg     <= (p_reg >= PW'(N));
        cur_reg      <= cur_next;
        cur_idx_reg  <= cur_idx_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            p_reg         <= '0;
            cidx_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            sel_reg       <= 1'b0;
            yacc_reg      <= 1'b0;
            young_reg     <= 1'b0;
            gen_reg       <= '0;
            clr_item_reg  <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            cidx_reg      <= cidx_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            sel_reg       <= sel_next;
            yacc_reg      <= yacc_next;
            young_reg     <= young_next;
            gen_reg       <= gen_next;
            clr_item_reg  <= clr_item_next;
            v1_reg        <= slot_live;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/aging_life_automaton_grid_unit.sv
// Top level of the aging life grid: configuration registers, front end and back end.
// Depends on ala_pkg, ala_front and ala_back.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one beat per command:
// write a cell, read a cell, step one generation or clear the grid. Every
// beat yields exactly one output beat (out_valid, out_stall, out_data) with the
// addressed cell after the command, the young flag and the generation count.
// A front queue of two entries takes beats while the back end works.
// Write and read commands pass from the queue through the read and response
// states to the result register. A generation sweeps the grid from one
// memory read port, one cell per cycle. A clear command writes one cell per
// cycle across the whole grid. After reset the back end empties the grid
// before it takes commands; the front queue still fills.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always ready and are meant for times when the block is idle.
// When out_stall is high the result is held and the back end waits.
module aging_life_automaton_grid_unit #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ala_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ala_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data
);
    import ala_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid;
    qitem_t q_item;
    logic   q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age        <= RST_MAX_AGE;
            cfg_reg.max_spawn_age  <= RST_MAX_SPAWN_AGE;
            cfg_reg.max_spirit_age <= RST_MAX_SPIRIT_AGE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_AGE:        cfg_reg.max_age        <= cfg_data;
                CFG_MAX_SPAWN_AGE:  cfg_reg.max_spawn_age  <= cfg_data;
                CFG_MAX_SPIRIT_AGE: cfg_reg.max_spirit_age <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    ala_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ala_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
